FILE: src/spq_pkg.sv
// Package for the sorted priority queue: command, result, entry and cell-control
// structs, status and action codes and the default depth. No dependencies.
package spq_pkg;

	localparam int DepthDef = 64;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef struct packed {
		logic               action;
		logic signed [15:0] priority_req;
		logic signed [31:0] payload;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] out_priority;
		logic signed [31:0] out_payload;
		logic [6:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] prio;
		logic signed [31:0] pay;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

FILE: src/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell instances plus
// the fill count and the result register. Depends on spq_pkg and spq_cell.
//
// Usage: a command (insert or remove) is transferred at a rising edge where
// start is high and busy is low. busy is never raised, so one command may be
// transferred every cycle. Every command gives exactly one result on rsp,
// marked by done, in the cycle after the transfer edge and for one cycle only.
// The receiver cannot stall; it must take the result in that cycle.
// All cells compare the new priority against their own in parallel and
// shift by one place toward the tail on an insert or toward the head on a
// remove, so the throughput is one per cycle.
// Equal priorities leave in the order they were inserted.
// An insert into a full queue is dropped with status full; a remove from an
// empty queue returns status empty. Reset clears the fill count and done;
// the cell contents are not cleared and are never read before written.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DepthDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spq_pkg::cmd_t cmd,
	output logic          done,
	output spq_pkg::rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]       count_q;
	logic                done_q;
	spq_pkg::rsp_t       rsp_q;
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::entry_t     new_ent;
	spq_pkg::entry_t     cell_ent [DEPTH];
	logic [DEPTH-1:0]    cell_stay;
	logic                full;
	logic                empty;
	logic [CW-1:0]       count_d;
	logic [31:0]         count_ext;

	assign busy  = 1'b0;
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign new_ent.prio = cmd.priority_req;
	assign new_ent.pay  = cmd.payload;

	assign ctrl.insert = start && (cmd.action == spq_pkg::ACT_INSERT) && !full;
	assign ctrl.remove = start && (cmd.action == spq_pkg::ACT_REMOVE) && !empty;

	always_comb begin
		count_d = count_q;
		if (ctrl.insert) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.remove) begin
			count_d = count_q - CW'(1);
		end
	end

	assign count_ext = 32'(count_d);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			spq_pkg::entry_t left_ent;
			spq_pkg::entry_t right_ent;
			logic            left_stay;
			if (gi == 0) begin : g_head
				assign left_ent  = new_ent;
				assign left_stay = 1'b1;
			end else begin : g_mid
				assign left_ent  = cell_ent[gi-1];
				assign left_stay = cell_stay[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign right_ent = cell_ent[gi];
			end else begin : g_body
				assign right_ent = cell_ent[gi+1];
			end
			spq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.new_ent   (new_ent),
				.occupied  (CW'(gi) < count_q),
				.left_ent  (left_ent),
				.left_stay (left_stay),
				.right_ent (right_ent),
				.ent       (cell_ent[gi]),
				.stay      (cell_stay[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rsp_q.status       <= spq_pkg::STAT_DONE;
			rsp_q.out_priority <= '0;
			rsp_q.out_payload  <= '0;
			rsp_q.occupancy    <= count_ext[6:0];
			if (cmd.action == spq_pkg::ACT_INSERT) begin
				if (full) begin
					rsp_q.status <= spq_pkg::STAT_FULL;
				end
			end else if (empty) begin
				rsp_q.status <= spq_pkg::STAT_EMPTY;
			end else begin
				rsp_q.out_priority <= cell_ent[0].prio;
				rsp_q.out_payload  <= cell_ent[0].pay;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: src/spq_cell.sv
// One cell of the sorted queue: holds one entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  spq_pkg::entry_t     new_ent,
	input  logic                occupied,
	input  spq_pkg::entry_t     left_ent,
	input  logic                left_stay,
	input  spq_pkg::entry_t     right_ent,
	output spq_pkg::entry_t     ent,
	output logic                stay
);

	spq_pkg::entry_t ent_q;

	assign ent  = ent_q;
	assign stay = occupied && (ent_q.prio <= new_ent.prio);

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!stay) begin
				ent_q <= left_stay ? new_ent : left_ent;
			end
		end else if (ctrl.remove) begin
			ent_q <= right_ent;
		end
	end

endmodule

FILE: tb/sv/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: directed and random insert/remove
// commands are checked against a sorted-array model of the queue kept here.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;

	localparam int Depth      = spq_pkg::DepthDef;
	localparam int CycleLimit = 150000;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	spq_pkg::cmd_t cmd;
	logic          done;
	spq_pkg::rsp_t rsp;

	spq_pkg::entry_t model_entries [Depth];
	int              model_count;
	spq_pkg::rsp_t   pending_results [$];
	int              mismatch_count;
	int              idle_pct;

	sorted_priority_queue #(.DEPTH(Depth)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic spq_pkg::rsp_t predict_queue_op(spq_pkg::cmd_t c);
		spq_pkg::rsp_t r;
		int            pos;
		int            i;
		r = '0;
		if (c.action == spq_pkg::ACT_INSERT) begin
			if (model_count >= Depth) begin
				r.status = spq_pkg::STAT_FULL;
			end else begin
				pos = 0;
				while (pos < model_count &&
					$signed(model_entries[pos].prio) <= $signed(c.priority_req))
					pos++;
				for (i = model_count; i > pos; i--)
					model_entries[i] = model_entries[i - 1];
				model_entries[pos].prio = c.priority_req;
				model_entries[pos].pay  = c.payload;
				model_count++;
				r.status = spq_pkg::STAT_DONE;
			end
		end else begin
			if (model_count == 0) begin
				r.status = spq_pkg::STAT_EMPTY;
			end else begin
				r.status       = spq_pkg::STAT_DONE;
				r.out_priority = model_entries[0].prio;
				r.out_payload  = model_entries[0].pay;
				for (i = 1; i < model_count; i++)
					model_entries[i - 1] = model_entries[i];
				model_count--;
			end
		end
		r.occupancy = 7'(model_count);
		return r;
	endfunction

	function automatic spq_pkg::cmd_t make_cmd(spq_pkg::action_t act, int prio, int pay);
		spq_pkg::cmd_t c;
		c.action       = act;
		c.priority_req = 16'(prio);
		c.payload      = 32'(pay);
		return c;
	endfunction

	// A command is transferred at the first rising edge with start high and busy low.
	task automatic send_cmd(spq_pkg::cmd_t c);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			cmd   <= spq_pkg::cmd_t'({$urandom, $urandom});
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_queue_op(c));
	endtask

	always @(posedge clk) begin
		spq_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d, occupancy %0d", rsp.status, rsp.occupancy);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.out_priority !== want.out_priority) begin
					$error("out_priority: expected %0d, actual %0d",
						want.out_priority, rsp.out_priority);
					mismatch_count++;
				end
				if (rsp.out_payload !== want.out_payload) begin
					$error("out_payload: expected %0d, actual %0d",
						want.out_payload, rsp.out_payload);
					mismatch_count++;
				end
				if (rsp.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, actual %0d", want.occupancy, rsp.occupancy);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_empty_remove();
		send_cmd(make_cmd(spq_pkg::ACT_REMOVE, 0, 0));
		send_cmd(make_cmd(spq_pkg::ACT_REMOVE, -1, -1));
	endtask

	task automatic test_field_extremes();
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 32767, 32'h7fffffff));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, -32768, 32'h80000000));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 0, 0));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, -1, -1));
		send_cmd(make_cmd(spq_pkg::ACT_REMOVE, 12345, 32'h5a5a5a5a));
		send_cmd(make_cmd(spq_pkg::ACT_REMOVE, -32768, 0));
		send_cmd(make_cmd(spq_pkg::ACT_REMOVE, 32767, -1));
		send_cmd(make_cmd(spq_pkg::ACT_REMOVE, 0, 0));
		send_cmd(make_cmd(spq_pkg::ACT_REMOVE, 1, 1));
	endtask

	// Entries with equal priority must leave in the order they were inserted.
	task automatic test_equal_priority_order();
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 5, 1));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 5, 2));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 3, 10));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 5, 3));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 9, 20));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 5, 4));
		repeat (6) send_cmd(make_cmd(spq_pkg::ACT_REMOVE, 0, 0));
	endtask

	task automatic test_full_queue();
		repeat (Depth)
			send_cmd(make_cmd(spq_pkg::ACT_INSERT, $urandom_range(0, 15), $urandom));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, -32768, 32'h80000000));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 32767, 32'h7fffffff));
		send_cmd(make_cmd(spq_pkg::ACT_REMOVE, 0, 0));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, $urandom_range(0, 15), $urandom));
		send_cmd(make_cmd(spq_pkg::ACT_INSERT, 0, 0));
		repeat (Depth + 1) send_cmd(make_cmd(spq_pkg::ACT_REMOVE, $urandom, $urandom));
	endtask

	task automatic test_random_traffic(int n_items);
		spq_pkg::cmd_t c;
		int            insert_pct;
		int            prio_mode;
		int            prio;
		int            k;
		insert_pct = 50;
		prio_mode  = 0;
		for (k = 0; k < n_items; k++) begin
			if (k % 32 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 15;
					1: insert_pct = 50;
					default: insert_pct = 85;
				endcase
				prio_mode = $urandom_range(0, 3);
			end
			case (prio_mode)
				0: prio = $urandom_range(0, 6) - 3;
				1: begin
					case ($urandom_range(0, 6))
						0: prio = -32768;
						1: prio = -32767;
						2: prio = -1;
						3: prio = 0;
						4: prio = 1;
						5: prio = 32766;
						default: prio = 32767;
					endcase
				end
				default: prio = $urandom;
			endcase
			c = make_cmd(($urandom_range(0, 99) < insert_pct) ?
				spq_pkg::ACT_INSERT : spq_pkg::ACT_REMOVE, prio, $urandom);
			send_cmd(c);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = '0;
		model_count    = 0;
		mismatch_count = 0;
		idle_pct       = 26;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_remove();
		test_field_extremes();
		test_equal_priority_order();
		test_full_queue();
		test_random_traffic(390);
		idle_pct = 71;
		test_random_traffic(390);
		idle_pct = 0;
		test_random_traffic(390);
		test_full_queue();

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("sorted_priority_queue: match");
		else
			$display("sorted_priority_queue: mismatch");
		$finish;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("sorted_priority_queue: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_tb.sv
